// File: rtl/core/hcbp_pkg.sv
package hcbp_pkg;

    // Operation codes carried in the opcode field
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ENC   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam int TABLE_DEPTH = 256;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int SYM_W       = 8;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_error;
        logic       last;
    } out_word_t;

    // One code table entry as held in the RAM
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage

// File: rtl/core/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read that holds when not enabled
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/huffman_code_bit_packer.sv
// Channel | Ports                      | Payload     | Direction
// s       | s_valid s_ready s_word     | in_word_t   | in  (load, encode, flush)
// m       | m_valid m_ready m_word     | out_word_t  | out (one packed byte per word)
//
// One item is taken per cycle while the byte emitter keeps up; an item passes from
// stage 1 (table read) to the emitter buffer; its first word is offered from there.
// An encode that completes k bytes holds the single-byte output port for k words
// (up to (MAX_CODE_LEN+7)/8), which sets the sustained rate for long codes.
// Reset clears the table valid bits, pending bits and all handshake state at once;
// no clearing pass. A stall on m backs up through the emitter to s_ready.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam int ACC_W     = MAX_CODE_LEN + 7;
    localparam int MAX_BYTES = ACC_W / 8;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam logic [6:0] ACC_W7 = 7'(ACC_W);

    logic s_acc;
    logic st1_adv;

    // Table: RAM plus one valid bit per entry
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   tbl_wr;
    entry_t                 wr_entry;
    entry_t                 rd_entry;
    logic                   len_ok;

    assign s_acc  = s_valid && s_ready;
    assign len_ok = s_word.code_len <= LEN_W'(MAX_CODE_LEN);
    assign tbl_wr = s_acc && (s_word.opcode == OP_LOAD) && len_ok
                    && (s_word.code_len != '0);

    always_comb begin
        wr_entry.code = s_word.code_bits & ~({CODE_W{1'b1}} << s_word.code_len);
        wr_entry.len  = s_word.code_len;
    end

    hcbp_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr),
        .wr_addr (s_word.symbol),
        .wr_data (wr_entry),
        .rd_en   (s_acc),
        .rd_addr (s_word.symbol),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (s_acc && (s_word.opcode == OP_LOAD) && len_ok) begin
            valid_reg[s_word.symbol] <= (s_word.code_len != '0);
        end
    end

    // Stage 1: item waiting on the table read
    logic       st1_valid_reg;
    logic [1:0] st1_op_reg;
    logic       st1_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st1_op_reg  <= s_word.opcode;
            st1_hit_reg <= valid_reg[s_word.symbol];
        end
    end

    // Accumulate pending bits with the looked-up code
    logic [6:0]       pend_reg;
    logic [2:0]       pcnt_reg;
    logic [6:0]       pend_next;
    logic [2:0]       pcnt_next;
    logic [LEN_W-1:0] clen;
    logic [6:0]       total;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] new_buf;
    logic [CNT_W-1:0] new_cnt;
    logic             new_err;

    always_comb begin
        clen      = st1_hit_reg ? rd_entry.len : '0;
        acc       = (ACC_W'(pend_reg) << clen) | ACC_W'(rd_entry.code);
        total     = 7'(pcnt_reg) + 7'(clen);
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        new_buf   = '0;
        new_cnt   = '0;
        new_err   = 1'b0;
        case (st1_op_reg)
            OP_ENC: begin
                if (clen == '0) begin
                    // missing entry: one error word, accumulator untouched
                    new_cnt = CNT_W'(1);
                    new_err = 1'b1;
                end else begin
                    new_buf   = acc << (ACC_W7 - total);
                    new_cnt   = CNT_W'(total[6:3]);
                    pend_next = acc[6:0] & ~(7'h7F << total[2:0]);
                    pcnt_next = total[2:0];
                end
            end
            OP_FLUSH: begin
                if (pcnt_reg != '0) begin
                    new_buf[ACC_W-1 -: 8] = 8'({1'b0, pend_reg} << (4'd8 - 4'(pcnt_reg)));
                    new_cnt   = CNT_W'(1);
                    pend_next = '0;
                    pcnt_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Byte emitter: left-aligned buffer, one byte per word
    logic [ACC_W-1:0] buf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             err_reg;
    logic             emit_free;
    logic             m_acc;

    assign m_acc     = m_valid && m_ready;
    assign emit_free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);
    assign st1_adv   = st1_valid_reg && ((new_cnt == '0) || emit_free);
    assign s_ready   = !st1_valid_reg || st1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end else if (st1_adv) begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (st1_adv && (new_cnt != '0)) begin
            cnt_reg <= new_cnt;
        end else if (m_acc) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv && (new_cnt != '0)) begin
            buf_reg <= new_buf;
            err_reg <= new_err;
        end else if (m_acc) begin
            buf_reg <= buf_reg << 8;
        end
    end

    assign m_valid         = cnt_reg != '0;
    assign m_word.out_byte = buf_reg[ACC_W-1 -: 8];
    assign m_word.is_error = err_reg;
    assign m_word.last     = cnt_reg == CNT_W'(1);

    // Checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_BYTES))
        else $error("emitter byte count out of range");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.is_error |-> m_word.last && (m_word.out_byte == 8'd0))
        else $error("error word must be a single zero byte marked last");

    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> st1_valid_reg && (cnt_reg != '0))
        else $error("input stalled with nothing held downstream");

    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !st1_adv |=> $stable(pcnt_reg) && $stable(pend_reg))
        else $error("pending bits changed without an item advancing");

endmodule
